[sv/vmmio_pkg.sv]
package vmmio_pkg;

  localparam int QUEUE_COUNT_DEF  = 2;
  localparam int CONFIG_BYTES_DEF = 64;

  typedef enum logic [1:0] {
    MODE_READ       = 2'd0,
    MODE_WRITE      = 2'd1,
    MODE_USED_EVENT = 2'd2,
    MODE_CFG_LOAD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_DEVICE_FEATURES = 2'd0,
    CFG_DEVICE_TYPE     = 2'd1,
    CFG_VENDOR_CODE     = 2'd2,
    CFG_QUEUE_SIZE_MAX  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PAGE_LOW  = 2'd0,
    PAGE_HIGH = 2'd1,
    PAGE_NONE = 2'd2
  } feat_page_t;

  // register window offsets
  localparam logic [8:0] OFF_MAGIC         = 9'h000;
  localparam logic [8:0] OFF_VERSION       = 9'h004;
  localparam logic [8:0] OFF_DEVICE_ID     = 9'h008;
  localparam logic [8:0] OFF_VENDOR_ID     = 9'h00C;
  localparam logic [8:0] OFF_DEV_FEATURES  = 9'h010;
  localparam logic [8:0] OFF_DEV_FEAT_SEL  = 9'h014;
  localparam logic [8:0] OFF_QUEUE_SEL     = 9'h030;
  localparam logic [8:0] OFF_QUEUE_NUM_MAX = 9'h034;
  localparam logic [8:0] OFF_QUEUE_READY   = 9'h044;
  localparam logic [8:0] OFF_QUEUE_NOTIFY  = 9'h050;
  localparam logic [8:0] OFF_INT_STATUS    = 9'h060;
  localparam logic [8:0] OFF_INT_ACK       = 9'h064;
  localparam logic [8:0] OFF_STATUS        = 9'h070;
  localparam logic [8:0] OFF_SHM_LEN_LO    = 9'h0B0;
  localparam logic [8:0] OFF_SHM_LEN_HI    = 9'h0B4;
  localparam logic [8:0] OFF_SHM_BASE_LO   = 9'h0B8;
  localparam logic [8:0] OFF_SHM_BASE_HI   = 9'h0BC;
  localparam logic [8:0] OFF_CONFIG_GEN    = 9'h0FC;

  localparam logic [31:0] MAGIC_WORD    = 32'h7472_6976;
  localparam logic [31:0] MMIO_VERSION  = 32'd2;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
  localparam int          DRIVER_OK_BIT = 2;

  localparam logic [63:0] DEVICE_FEATURES_RST = 64'h0000_0001_0000_0000;
  localparam logic [7:0]  DEVICE_TYPE_RST     = 8'd26;
  localparam logic [31:0] VENDOR_CODE_RST     = 32'd0;
  localparam logic [15:0] QUEUE_SIZE_MAX_RST  = 16'd1024;

  typedef struct packed {
    logic       rd_en;
    logic [7:0] rd_idx;
    logic       wr_en;
    logic [7:0] wr_idx;
    logic [7:0] wr_byte;
  } cfgmem_req_t;

endpackage

[sv/vmmio_cfg_mem.sv]
module vmmio_cfg_mem #(
  parameter int CONFIG_BYTES = vmmio_pkg::CONFIG_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vmmio_pkg::cfgmem_req_t req,
  output logic [31:0]            rd_word
);
  import vmmio_pkg::*;

  localparam int ROWS = (CONFIG_BYTES + 3) / 4;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [3:0][7:0] bank_rd;
  logic [3:0]      bank_hit;
  logic [1:0]      lane0_r;

  // four byte banks so an unaligned word read touches each bank once
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [8:0]    idx;
    logic          in_rng;
    logic [RW-1:0] rd_row;
    logic [RW-1:0] wr_row;
    logic          wr_sel;
    logic [7:0]    bank_mem_r [ROWS];
    logic [ROWS-1:0] vld_r;
    logic [7:0]    data_r;
    logic          hit_r;

    assign idx    = {1'b0, req.rd_idx} + {7'd0, 2'(2'(k) - req.rd_idx[1:0])};
    assign in_rng = idx < 9'(CONFIG_BYTES);
    assign rd_row = in_rng ? idx[RW+1:2] : '0;
    assign wr_row = req.wr_idx[RW+1:2];
    assign wr_sel = req.wr_en && (req.wr_idx[1:0] == 2'(k));

    always_ff @(posedge clk) begin
      if (wr_sel) begin
        bank_mem_r[wr_row] <= req.wr_byte;
      end
      if (req.rd_en) begin
        data_r <= bank_mem_r[rd_row];
        hit_r  <= in_rng && vld_r[rd_row];
      end
    end

    // never-loaded bytes read as zero
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= '0;
      end else if (wr_sel) begin
        vld_r[wr_row] <= 1'b1;
      end
    end

    assign bank_rd[k]  = data_r;
    assign bank_hit[k] = hit_r;
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      lane0_r <= req.rd_idx[1:0];
    end
  end

  always_comb begin
    logic [1:0] b;
    rd_word = '0;
    for (int i = 0; i < 4; i++) begin
      b = 2'(lane0_r + 2'(i));
      rd_word[8*i +: 8] = bank_hit[b] ? bank_rd[b] : 8'h00;
    end
  end

endmodule

[sv/virtio_mmio_transport_regs.sv]
// virtio-mmio v2 transport register window, device side
// the accepted word passes through the input register, then the result register
// throughput: one word per cycle while out_stall does not hold the result; the config-space read is one
// registered bank read issued when the word is accepted, so it lands alongside the input register
// reset: rst_n synchronous active low; clears status, queue state and valid bits,
// loads the default identity and feature registers; no clearing pass is needed
module virtio_mmio_transport_regs #(
  parameter int QUEUE_COUNT  = vmmio_pkg::QUEUE_COUNT_DEF,
  parameter int CONFIG_BYTES = vmmio_pkg::CONFIG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [8:0]  in_offset,
  input  logic [2:0]  in_access_size,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_line,
  output logic        out_notify_valid,
  output logic [3:0]  out_notify_queue,
  output logic        out_driver_ok_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import vmmio_pkg::*;

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  logic [63:0] dev_features_r;
  logic [7:0]  dev_type_r;
  logic [31:0] vendor_r;
  logic [15:0] qsize_max_r;

  logic        in_accept;
  logic        s1_adv;
  logic        s1_valid_r;
  mode_t       s1_mode_r;
  logic [8:0]  s1_off_r;
  logic [2:0]  s1_size_r;
  logic [31:0] s1_data_r;

  feat_page_t  feat_page_r, feat_page_nxt;
  logic        sel_ok_r, sel_ok_nxt;
  logic [QW-1:0] sel_idx_r, sel_idx_nxt;
  logic [31:0] queue_ready_r   [QUEUE_COUNT];
  logic [31:0] queue_ready_nxt [QUEUE_COUNT];
  logic        isr_r, isr_nxt;
  logic [31:0] dev_status_r, dev_status_nxt;
  logic        irq_r, irq_nxt;

  logic        out_valid_r;
  logic [31:0] out_read_data_r;
  logic        out_irq_r;
  logic        out_notify_valid_r;
  logic [3:0]  out_notify_queue_r;
  logic        out_dok_r;

  logic [31:0] mask;
  logic [31:0] val;
  logic [31:0] rd_raw;
  logic        cfg_hit;
  logic [31:0] cfg_word;
  logic        nvalid;
  logic [3:0]  nqueue;
  logic        dok;
  cfgmem_req_t mem_req;

  // configuration port; the user must write it only while idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_features_r <= DEVICE_FEATURES_RST;
      dev_type_r     <= DEVICE_TYPE_RST;
      vendor_r       <= VENDOR_CODE_RST;
      qsize_max_r    <= QUEUE_SIZE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DEVICE_FEATURES: dev_features_r <= cfg_data;
        CFG_DEVICE_TYPE:     dev_type_r     <= cfg_data[7:0];
        CFG_VENDOR_CODE:     vendor_r       <= cfg_data[31:0];
        CFG_QUEUE_SIZE_MAX:  qsize_max_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_accept = in_valid && !in_stall;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r <= mode_t'(in_mode);
      s1_off_r  <= in_offset;
      s1_size_r <= in_access_size;
      s1_data_r <= in_write_data;
    end
  end

  // config space: loads and reads go to the banks as words are accepted
  always_comb begin
    mem_req.rd_en   = in_accept && (mode_t'(in_mode) == MODE_READ);
    mem_req.rd_idx  = in_offset[7:0];
    mem_req.wr_en   = in_accept && (mode_t'(in_mode) == MODE_CFG_LOAD)
                      && (in_offset < 9'(CONFIG_BYTES));
    mem_req.wr_idx  = in_offset[7:0];
    mem_req.wr_byte = in_write_data[7:0];
  end

  vmmio_cfg_mem #(
    .CONFIG_BYTES(CONFIG_BYTES)
  ) u_cfg_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_word (cfg_word)
  );

  always_comb begin
    case (s1_size_r)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = ALL_ONES;
    endcase
  end

  assign val     = s1_data_r & mask;
  assign cfg_hit = s1_off_r[8] && ({1'b0, s1_off_r[7:0]} < 9'(CONFIG_BYTES));

  // read decode
  always_comb begin
    case (s1_off_r)
      OFF_MAGIC:         rd_raw = MAGIC_WORD;
      OFF_VERSION:       rd_raw = MMIO_VERSION;
      OFF_DEVICE_ID:     rd_raw = {24'd0, dev_type_r};
      OFF_VENDOR_ID:     rd_raw = vendor_r;
      OFF_DEV_FEATURES: begin
        case (feat_page_r)
          PAGE_LOW:  rd_raw = dev_features_r[31:0];
          PAGE_HIGH: rd_raw = dev_features_r[63:32];
          default:   rd_raw = '0;
        endcase
      end
      OFF_QUEUE_NUM_MAX: rd_raw = {16'd0, qsize_max_r};
      OFF_QUEUE_READY:   rd_raw = sel_ok_r ? queue_ready_r[sel_idx_r] : '0;
      OFF_INT_STATUS:    rd_raw = {31'd0, isr_r};
      OFF_STATUS:        rd_raw = dev_status_r;
      OFF_CONFIG_GEN:    rd_raw = '0;
      OFF_SHM_LEN_LO, OFF_SHM_LEN_HI, OFF_SHM_BASE_LO, OFF_SHM_BASE_HI: rd_raw = ALL_ONES;
      default:           rd_raw = cfg_hit ? cfg_word : '0;
    endcase
  end

  // state update; queue sizes, ring addresses, driver features and the
  // shared memory select have no reader in this window and are not kept
  always_comb begin
    feat_page_nxt  = feat_page_r;
    sel_ok_nxt     = sel_ok_r;
    sel_idx_nxt    = sel_idx_r;
    isr_nxt        = isr_r;
    dev_status_nxt = dev_status_r;
    irq_nxt        = irq_r;
    nvalid         = 1'b0;
    nqueue         = '0;
    dok            = 1'b0;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      queue_ready_nxt[q] = queue_ready_r[q];
    end
    if (s1_adv) begin
      case (s1_mode_r)
        MODE_WRITE: begin
          case (s1_off_r)
            OFF_DEV_FEAT_SEL: begin
              if (val == 32'd0) begin
                feat_page_nxt = PAGE_LOW;
              end else if (val == 32'd1) begin
                feat_page_nxt = PAGE_HIGH;
              end else begin
                feat_page_nxt = PAGE_NONE;
              end
            end
            OFF_QUEUE_SEL: begin
              sel_ok_nxt  = val < 32'(QUEUE_COUNT);
              sel_idx_nxt = (val < 32'(QUEUE_COUNT)) ? val[QW-1:0] : '0;
            end
            OFF_QUEUE_READY: begin
              if (sel_ok_r) begin
                queue_ready_nxt[sel_idx_r] = val;
              end
            end
            OFF_QUEUE_NOTIFY: begin
              if (val < 32'(QUEUE_COUNT)) begin
                nvalid = 1'b1;
                nqueue = val[3:0];
              end
            end
            OFF_INT_ACK: begin
              isr_nxt = isr_r & ~val[0];
              if (!isr_nxt) begin
                irq_nxt = 1'b0;
              end
            end
            OFF_STATUS: begin
              dev_status_nxt = val;
              if (val == 32'd0) begin
                isr_nxt = 1'b0;
                for (int q = 0; q < QUEUE_COUNT; q++) begin
                  queue_ready_nxt[q] = '0;
                end
              end
              dok = val[DRIVER_OK_BIT] && !dev_status_r[DRIVER_OK_BIT];
            end
            default: ;
          endcase
        end
        MODE_USED_EVENT: begin
          isr_nxt = 1'b1;
          irq_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_page_r  <= PAGE_LOW;
      sel_ok_r     <= (QUEUE_COUNT > 0);
      sel_idx_r    <= '0;
      isr_r        <= 1'b0;
      dev_status_r <= '0;
      irq_r        <= 1'b0;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        queue_ready_r[q] <= '0;
      end
    end else begin
      feat_page_r  <= feat_page_nxt;
      sel_ok_r     <= sel_ok_nxt;
      sel_idx_r    <= sel_idx_nxt;
      isr_r        <= isr_nxt;
      dev_status_r <= dev_status_nxt;
      irq_r        <= irq_nxt;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        queue_ready_r[q] <= queue_ready_nxt[q];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_read_data_r    <= (s1_mode_r == MODE_READ) ? (rd_raw & mask) : '0;
      out_irq_r          <= irq_nxt;
      out_notify_valid_r <= nvalid;
      out_notify_queue_r <= nqueue;
      out_dok_r          <= dok;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_read_data_r;
  assign out_irq_line        = out_irq_r;
  assign out_notify_valid    = out_notify_valid_r;
  assign out_notify_queue    = out_notify_queue_r;
  assign out_driver_ok_event = out_dok_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked word in flight");

  a_notify_queue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_notify_valid_r |-> out_notify_queue_r == 4'd0)
    else $error("notify queue set without notify");

  a_driver_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && dok |=> dev_status_r[DRIVER_OK_BIT])
    else $error("driver ok event without status bit");

  a_used_event_irq: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_mode_r == MODE_USED_EVENT) |=> irq_r && isr_r && out_irq_r)
    else $error("used buffer event did not raise the line");

endmodule
